// ===== rtl/rcwt_pkg.sv =====
// Shared types and constants for the textured wall column pixel pipeline.
// Depends on nothing; the top, rcwt_rowcalc and the testbench import it.
`default_nettype none

package rcwt_pkg;

    // 623.25 in Q16, the numerator of the wall height.
    localparam logic [25:0] HEIGHT_NUM = 26'd40845312;
    localparam int          HEIGHT_QW  = 16;

    // Configuration register indexes.
    localparam logic CFG_CEILING = 1'b0;
    localparam logic CFG_FLOOR   = 1'b1;

    // Item kinds carried in tuser.
    localparam logic ACT_WRITE = 1'b0;
    localparam logic ACT_PIXEL = 1'b1;

    // Where a pixel colour comes from.
    typedef enum logic [1:0] {
        SRC_TEXEL,
        SRC_CEILING,
        SRC_FLOOR
    } t_src;

    // Row control that travels with the texel row division.
    typedef struct packed {
        t_src src;
        logic lower;       // lower half of the wall: quotient minus one
        logic force_zero;  // upper numerator not positive: row zero
        logic hzero;       // zero height: centre texel row
    } t_rowctl;

endpackage

`default_nettype wire

// ===== rtl/raycast_wall_column_texel.sv =====
// Textured wall column pixel pipeline: takes one request per cycle when the
// output is not stalled, either a texel write into one of four square textures
// or a pixel query, and returns one pixel result per query, in order, one per
// cycle when the output is not stalled. The wall height divider takes 17
// stages and the texel row divider log2(TEX_SIZE) + 2, and the texture RAM
// read fills the last stage. The whole pipeline stops while a result waits on
// the output. TEX_SIZE must be a power of two. Texels must be written before a
// pixel reads them. Depends on rcwt_pkg, rcwt_div, rcwt_rowcalc and rcwt_ram.
`default_nettype none

module raycast_wall_column_texel
    import rcwt_pkg::*;
#(
    parameter int TEX_SIZE      = 64,
    parameter int SCREEN_HEIGHT = 450
) (
    input  wire          i_clk,
    input  wire          i_rst_n,
    input  wire          i_cfg_we,
    input  wire          i_cfg_addr,
    input  wire  [23:0]  i_cfg_wdata,
    input  wire          i_s_tvalid,
    output logic         o_s_tready,
    // tdata: screen_column[9:0], screen_row[18:10], ray_length[42:19],
    // hit_x[66:43], hit_y[90:67], hit_axis[91], wall_side[93:92],
    // texel_index[105:94], texel_value[137:106], zero fill above
    input  wire  [143:0] i_s_tdata,
    // tuser: action
    input  wire          i_s_tuser,
    output logic         o_m_tvalid,
    input  wire          i_m_tready,
    // tdata: out_column[9:0], out_row[18:10], pixel_colour[50:19], zero fill above
    output logic [55:0]  o_m_tdata
);

    localparam int TW  = $clog2(TEX_SIZE);
    localparam int TAW = 2 * TW;
    localparam int AW  = TAW + 2;
    localparam int QW2 = TW + 1;
    localparam int NW2 = HEIGHT_QW + TW + 2;
    localparam int PW1 = 1 + 10 + 9 + 2 + TW + TAW + 32;
    localparam int CW  = $bits(t_rowctl);
    localparam int PW2 = PW1 + CW;

    logic w_adv;

    // Configuration registers.
    logic [23:0] r_ceiling;
    logic [23:0] r_floor;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ceiling <= '0;
            r_floor   <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                CFG_CEILING: r_ceiling <= i_cfg_wdata;
                CFG_FLOOR:   r_floor   <= i_cfg_wdata;
                default:     r_ceiling <= r_ceiling;
            endcase
        end
    end

    // The pipeline moves as one unless a result waits on the output.
    assign w_adv      = !o_m_tvalid || i_m_tready;
    assign o_s_tready = w_adv;

    // Input register.
    logic         r0_vld;
    logic         r0_act;
    logic [9:0]   r0_col;
    logic [8:0]   r0_row;
    logic [23:0]  r0_len;
    logic [15:0]  r0_frac;
    logic [1:0]   r0_side;
    logic [11:0]  r0_idx;
    logic [31:0]  r0_val;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r0_vld <= 1'b0;
        end else if (w_adv) begin
            r0_vld <= i_s_tvalid;
        end
        if (w_adv) begin
            r0_act  <= i_s_tuser;
            r0_col  <= i_s_tdata[9:0];
            r0_row  <= i_s_tdata[18:10];
            r0_len  <= i_s_tdata[42:19];
            r0_frac <= i_s_tdata[91] ? i_s_tdata[82:67] : i_s_tdata[58:43];
            r0_side <= i_s_tdata[93:92];
            r0_idx  <= i_s_tdata[105:94];
            r0_val  <= i_s_tdata[137:106];
        end
    end

    // Texture column: fraction times TEX_SIZE, rounded half up, clamped.
    logic [16+TW:0] w_tsum;
    logic [TW:0]    w_tcw;
    logic [TW-1:0]  w_tcol;
    logic [PW1-1:0] w_side1;

    assign w_tsum  = {1'b0, r0_frac, {TW{1'b0}}} + (17 + TW)'(32768);
    assign w_tcw   = w_tsum[16+TW:16];
    assign w_tcol  = (w_tcw > (TW + 1)'(TEX_SIZE - 1)) ? TW'(TEX_SIZE - 1) : w_tcw[TW-1:0];
    assign w_side1 = {r0_val, TAW'(r0_idx), w_tcol, r0_side, r0_row, r0_col, r0_act};

    // Wall height divider.
    logic                 d1_vld;
    logic [HEIGHT_QW-1:0] d1_quo;
    logic                 d1_ovf;
    logic [PW1-1:0]       d1_side;
    logic [8:0]           d1_row;

    rcwt_div #(
        .NW (26),
        .DW (24),
        .QW (HEIGHT_QW),
        .PW (PW1)
    ) u_hdiv (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (w_adv),
        .i_vld   (r0_vld),
        .i_num   (HEIGHT_NUM),
        .i_den   (r0_len),
        .i_side  (w_side1),
        .o_vld   (d1_vld),
        .o_quo   (d1_quo),
        .o_ovf   (d1_ovf),
        .o_side  (d1_side)
    );

    assign d1_row = d1_side[19:11];

    // Height, region and texel row numerator.
    logic           rc_vld;
    logic [NW2-1:0] rc_num;
    logic [16:0]    rc_den;
    t_rowctl        rc_ctl;
    logic [PW1-1:0] rc_side;

    rcwt_rowcalc #(
        .TEX_SIZE      (TEX_SIZE),
        .SCREEN_HEIGHT (SCREEN_HEIGHT),
        .PW            (PW1)
    ) u_rowcalc (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (w_adv),
        .i_vld   (d1_vld),
        .i_quo   (d1_quo),
        .i_ovf   (d1_ovf),
        .i_row   (d1_row),
        .i_side  (d1_side),
        .o_vld   (rc_vld),
        .o_num   (rc_num),
        .o_den   (rc_den),
        .o_ctl   (rc_ctl),
        .o_side  (rc_side)
    );

    // Texel row divider.
    logic           d2_vld;
    logic [QW2-1:0] d2_quo;
    logic           d2_ovf;
    logic [PW2-1:0] d2_side;

    rcwt_div #(
        .NW (NW2),
        .DW (17),
        .QW (QW2),
        .PW (PW2)
    ) u_rdiv (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (w_adv),
        .i_vld   (rc_vld),
        .i_num   (rc_num),
        .i_den   (rc_den),
        .i_side  ({rc_ctl, rc_side}),
        .o_vld   (d2_vld),
        .o_quo   (d2_quo),
        .o_ovf   (d2_ovf),
        .o_side  (d2_side)
    );

    // Unpack the item after the row division.
    t_rowctl        s_ctl;
    logic [31:0]    s_val;
    logic [TAW-1:0] s_idx;
    logic [TW-1:0]  s_tcol;
    logic [1:0]     s_side;
    logic [8:0]     s_row;
    logic [9:0]     s_col;
    logic           s_act;

    assign {s_ctl, s_val, s_idx, s_tcol, s_side, s_row, s_col, s_act} = d2_side;

    // Texel row: centre row for zero height, minus one in the lower half, clamped.
    logic [QW2-1:0] w_qadj;
    logic [TW-1:0]  w_trow;

    assign w_qadj = s_ctl.lower ? (d2_quo - QW2'(1)) : d2_quo;

    always_comb begin
        if (s_ctl.hzero) begin
            w_trow = TW'(TEX_SIZE / 2);
        end else if (s_ctl.force_zero) begin
            w_trow = '0;
        end else if (d2_ovf || w_qadj >= QW2'(TEX_SIZE)) begin
            w_trow = TW'(TEX_SIZE - 1);
        end else begin
            w_trow = w_qadj[TW-1:0];
        end
    end

    // Texture store access: writes and texel reads share one port.
    logic          w_ram_we;
    logic          w_ram_re;
    logic [AW-1:0] w_ram_addr;
    logic [31:0]   w_ram_rdata;

    assign w_ram_we   = w_adv && d2_vld && (s_act == ACT_WRITE);
    assign w_ram_re   = w_adv && d2_vld && (s_act == ACT_PIXEL) && (s_ctl.src == SRC_TEXEL);
    assign w_ram_addr = (s_act == ACT_WRITE) ? {s_side, s_idx} : {s_side, w_trow, s_tcol};

    rcwt_ram #(
        .WIDTH (32),
        .DEPTH (4 * TEX_SIZE * TEX_SIZE)
    ) u_tex (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_re    (w_ram_re),
        .i_addr  (w_ram_addr),
        .i_wdata (s_val),
        .o_rdata (w_ram_rdata)
    );

    // Output register, held while the output is stalled.
    logic        r_out_vld;
    logic [9:0]  r_out_col;
    logic [8:0]  r_out_row;
    t_src        r_out_src;
    logic [23:0] r_out_flat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_adv) begin
            r_out_vld <= d2_vld && (s_act == ACT_PIXEL);
        end
        if (w_adv) begin
            r_out_col  <= s_col;
            r_out_row  <= s_row;
            r_out_src  <= s_ctl.src;
            r_out_flat <= (s_ctl.src == SRC_CEILING) ? r_ceiling : r_floor;
        end
    end

    assign o_m_tvalid = r_out_vld;
    assign o_m_tdata  = {5'd0,
                         (r_out_src == SRC_TEXEL) ? w_ram_rdata : {8'd0, r_out_flat},
                         r_out_row, r_out_col};

    // The lower half always divides to at least one, so the minus one never wraps.
    a_lower_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (d2_vld && s_ctl.src == SRC_TEXEL && s_ctl.lower && !s_ctl.hzero)
        |-> (d2_ovf || d2_quo != '0))
        else $error("lower wall row quotient is zero");

    // The upper half never exceeds the centre texel row.
    a_upper_fits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (d2_vld && s_ctl.src == SRC_TEXEL && !s_ctl.lower && !s_ctl.force_zero
         && !s_ctl.hzero) |-> (!d2_ovf && d2_quo <= QW2'(TEX_SIZE / 2)))
        else $error("upper wall row quotient out of range");

    // The RAM read data must hold while a texel result is stalled.
    a_hold_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!w_adv) |-> (!w_ram_re && !w_ram_we))
        else $error("texture store accessed during a stall");

    // A zero height can only reach the wall at the centre row.
    a_hzero_centre: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (d2_vld && s_ctl.src == SRC_TEXEL && s_ctl.hzero) |-> !s_ctl.lower)
        else $error("zero height wall row off centre");

endmodule

`default_nettype wire

// ===== rtl/rcwt_ram.sv =====
// Generic single-port RAM with a registered read port.
// Depends on nothing.
`default_nettype none

module rcwt_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16384
) (
    input  wire                      i_clk,
    input  wire                      i_we,
    input  wire                      i_re,
    input  wire  [$clog2(DEPTH)-1:0] i_addr,
    input  wire  [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [0:DEPTH-1];

    // One access per cycle: write or registered read.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_addr];
        end
    end

endmodule

`default_nettype wire

// ===== rtl/rcwt_div.sv =====
// Pipelined restoring divider, one quotient bit per stage, with an overflow flag
// when the quotient does not fit. Depends on nothing; carries a sideband vector.
`default_nettype none

module rcwt_div #(
    parameter int NW = 26,
    parameter int DW = 24,
    parameter int QW = 16,
    parameter int PW = 8
) (
    input  wire           i_clk,
    input  wire           i_rst_n,
    input  wire           i_adv,
    input  wire           i_vld,
    input  wire  [NW-1:0] i_num,
    input  wire  [DW-1:0] i_den,
    input  wire  [PW-1:0] i_side,
    output logic          o_vld,
    output logic [QW-1:0] o_quo,
    output logic          o_ovf,
    output logic [PW-1:0] o_side
);

    localparam int WW = (NW > DW + QW) ? NW : DW + QW;

    logic          r_vld  [0:QW];
    logic [WW-1:0] r_rem  [0:QW];
    logic [DW-1:0] r_den  [0:QW];
    logic [QW-1:0] r_quo  [0:QW];
    logic          r_ovf  [0:QW];
    logic [PW-1:0] r_side [0:QW];

    // Entry stage: overflow when the dividend reaches the divisor times 2^QW.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld[0] <= 1'b0;
        end else if (i_adv) begin
            r_vld[0] <= i_vld;
        end
        if (i_adv) begin
            r_rem[0]  <= WW'(i_num);
            r_den[0]  <= i_den;
            r_quo[0]  <= '0;
            r_ovf[0]  <= (WW'(i_num) >= (WW'(i_den) << QW));
            r_side[0] <= i_side;
        end
    end

    // One compare and subtract per stage, most significant bit first.
    for (genvar j = 1; j <= QW; j++) begin : g_stage
        logic [WW-1:0] n_shd;
        logic          n_bit;
        assign n_shd = WW'(r_den[j-1]) << (QW - j);
        assign n_bit = (r_rem[j-1] >= n_shd);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[j] <= 1'b0;
            end else if (i_adv) begin
                r_vld[j] <= r_vld[j-1];
            end
            if (i_adv) begin
                r_rem[j]  <= n_bit ? (r_rem[j-1] - n_shd) : r_rem[j-1];
                r_den[j]  <= r_den[j-1];
                r_quo[j]  <= r_quo[j-1] | (QW'(n_bit) << (QW - j));
                r_ovf[j]  <= r_ovf[j-1];
                r_side[j] <= r_side[j-1];
            end
        end
    end

    assign o_vld  = r_vld[QW];
    assign o_quo  = r_quo[QW];
    assign o_ovf  = r_ovf[QW];
    assign o_side = r_side[QW];

endmodule

`default_nettype wire

// ===== rtl/rcwt_rowcalc.sv =====
// Wall height stage: saturates the height, sorts the row into ceiling, wall or
// floor, and forms the texel row numerator and divisor. Depends on rcwt_pkg.
`default_nettype none

module rcwt_rowcalc
    import rcwt_pkg::*;
#(
    parameter int TEX_SIZE      = 64,
    parameter int SCREEN_HEIGHT = 450,
    parameter int PW            = 8
) (
    input  wire                             i_clk,
    input  wire                             i_rst_n,
    input  wire                             i_adv,
    input  wire                             i_vld,
    input  wire  [HEIGHT_QW-1:0]            i_quo,
    input  wire                             i_ovf,
    input  wire  [8:0]                      i_row,
    input  wire  [PW-1:0]                   i_side,
    output logic                            o_vld,
    output logic [HEIGHT_QW+$clog2(TEX_SIZE)+1:0] o_num,
    output logic [HEIGHT_QW:0]              o_den,
    output t_rowctl                         o_ctl,
    output logic [PW-1:0]                   o_side
);

    localparam int TW  = $clog2(TEX_SIZE);
    localparam int NW  = HEIGHT_QW + TW + 2;
    localparam int SHB = $clog2(SCREEN_HEIGHT + 1);
    localparam int RW  = (SHB > 9) ? SHB : 9;

    logic [HEIGHT_QW-1:0] w_h;
    logic [HEIGHT_QW-1:0] w_lim;
    logic [HEIGHT_QW-1:0] w_half;
    logic [RW-1:0]        w_row;
    logic [RW-1:0]        w_centre;
    logic [RW-1:0]        w_d;
    logic                 w_above;
    logic                 w_wall;
    logic [NW-1:0]        w_a;
    logic [NW-1:0]        w_b;
    t_rowctl              w_ctl;

    // Height saturates at its full range; half height uses the screen limit.
    assign w_h      = i_ovf ? {HEIGHT_QW{1'b1}} : i_quo;
    assign w_lim    = (w_h > HEIGHT_QW'(SCREEN_HEIGHT)) ? HEIGHT_QW'(SCREEN_HEIGHT) : w_h;
    assign w_half   = w_lim >> 1;
    assign w_row    = RW'(i_row);
    assign w_centre = RW'(SCREEN_HEIGHT / 2);
    assign w_above  = (w_row < w_centre);
    assign w_d      = w_above ? (w_centre - w_row) : (w_row - w_centre);
    assign w_wall   = (HEIGHT_QW'(w_d) <= w_half);

    // Numerator terms: h*(2C+1) and 2*d*TEX_SIZE.
    assign w_a = NW'(w_h) * NW'(TEX_SIZE + 1);
    assign w_b = NW'(w_d) << (TW + 1);

    // Region and row control.
    always_comb begin
        w_ctl.lower      = 1'b0;
        w_ctl.force_zero = 1'b0;
        w_ctl.hzero      = (w_h == '0);
        if (w_row >= RW'(SCREEN_HEIGHT)) begin
            w_ctl.src = SRC_FLOOR;
        end else if (!w_wall) begin
            w_ctl.src = w_above ? SRC_CEILING : SRC_FLOOR;
        end else begin
            w_ctl.src = SRC_TEXEL;
            if (!w_above && w_d != '0) begin
                w_ctl.lower = 1'b1;
            end else begin
                w_ctl.force_zero = (w_a <= w_b);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_vld <= 1'b0;
        end else if (i_adv) begin
            o_vld <= i_vld;
        end
        if (i_adv) begin
            o_num  <= w_ctl.lower ? (w_a + w_b) : (w_a - w_b);
            o_den  <= {w_h, 1'b0};
            o_ctl  <= w_ctl;
            o_side <= i_side;
        end
    end

endmodule

`default_nettype wire

// ===== test/tb_raycast_wall_column_texel.sv =====
// Testbench for the textured wall column pixel pipeline: loads texels,
// queries pixels and checks each result against an in-bench predictor.
// Depends on rcwt_pkg and raycast_wall_column_texel.
`default_nettype none

module tb_raycast_wall_column_texel
    import rcwt_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int TEX      = 64;
    localparam int AREA     = TEX * TEX;
    localparam int SCRH     = 450;
    localparam int LAT      = 28;
    localparam int WATCHDOG = 2000;
    localparam int N_ITEMS  = 500;

    // Result fields in the order they sit in tdata, highest first.
    typedef struct packed {
        logic [31:0] colour;
        logic [8:0]  row;
        logic [9:0]  column;
    } t_pixel;

    typedef struct {
        logic         kind;
        logic [143:0] data;
        logic [23:0]  cfg_val;
        logic         cfg_idx;
        bit           is_cfg;
        bit           is_drain;
    } t_request;

    logic         i_clk = 0;
    logic         i_rst_n = 0;
    logic         i_cfg_we = 0;
    logic         i_cfg_addr = 0;
    logic [23:0]  i_cfg_wdata = 0;
    logic         i_s_tvalid = 0;
    logic         o_s_tready;
    logic [143:0] i_s_tdata = 0;
    logic         i_s_tuser = 0;
    logic         o_m_tvalid;
    logic         i_m_tready = 0;
    logic [55:0]  o_m_tdata;

    raycast_wall_column_texel DUT (.*);

    // Predictor state: texture copy and the two flat colours.
    logic [31:0] tex_words [4*AREA];
    logic [23:0] ceil_rgb = '0;
    logic [23:0] floor_rgb = '0;

    // Texels that the generated stream writes before any read of them.
    bit          gen_written [4*AREA];
    int          n_items = 0;

    t_request pending[$];
    t_pixel   expected_pixels[$];
    int       mismatches = 0;
    int       pixels_seen = 0;
    int       writes_sent = 0;
    bit       quiet = 0;
    int       hold_off = 0;
    bit       hold_done = 0;
    bit       stimulus_done = 0;

    initial forever #5 i_clk = ~i_clk;

    // Texel row for the wall, rounding half up with clamps at the edges.
    function automatic int texel_row(longint h, longint d, bit lower);
        longint num, r;
        if (h == 0) return TEX / 2;
        if (!lower) begin
            num = 2 * ((TEX / 2) * h - d * TEX) + h;
            if (num <= 0) return 0;
            r = num / (2 * h);
        end else begin
            num = 2 * ((TEX / 2) * h + d * TEX) + h;
            r = num / (2 * h) - 1;
        end
        if (r < 0) r = 0;
        if (r > TEX - 1) r = TEX - 1;
        return int'(r);
    endfunction

    // Store address of the texel a pixel request reads, or -1 for a flat colour.
    function automatic int texel_addr(logic [143:0] td);
        longint h, half, d, tcol, row, len, frac;
        int trow;
        row  = longint'(td[18:10]);
        len  = longint'(td[42:19]);
        frac = td[91] ? longint'(td[82:67]) : longint'(td[58:43]);
        if (row >= SCRH) return -1;
        h = (len == 0) ? 65535 : longint'(HEIGHT_NUM) / len;
        if (h > 65535) h = 65535;
        half = ((h > SCRH) ? SCRH : h) / 2;
        d = (row < SCRH / 2) ? SCRH / 2 - row : row - SCRH / 2;
        if (d > half) return -1;
        tcol = (frac * TEX + 32768) >> 16;
        if (tcol > TEX - 1) tcol = TEX - 1;
        trow = texel_row(h, d, row > SCRH / 2);
        return int'(td[93:92]) * AREA + trow * TEX + int'(tcol);
    endfunction

    // Predict the colour of one pixel request.
    function automatic logic [31:0] pixel_colour(logic [143:0] td);
        int addr;
        addr = texel_addr(td);
        if (addr >= 0) return tex_words[addr];
        if (td[18:10] < 9'(SCRH / 2)) return {8'd0, ceil_rgb};
        return {8'd0, floor_rgb};
    endfunction

    function automatic logic [143:0] rand_fields();
        logic [143:0] td;
        td = '0;
        td[9:0]   = 10'($urandom);
        td[18:10] = ($urandom_range(0, 9) == 0) ? 9'($urandom_range(450, 511))
                                                : 9'($urandom_range(0, 449));
        case ($urandom_range(0, 3))
            0:       td[42:19] = 24'($urandom_range(0, 4096));
            1:       td[42:19] = 24'($urandom_range(90000, 400000));
            2:       td[42:19] = 24'($urandom);
            default: td[42:19] = 24'($urandom_range(0, 100000));
        endcase
        td[66:43]   = 24'($urandom);
        td[90:67]   = 24'($urandom);
        td[91]      = 1'($urandom);
        td[93:92]   = 2'($urandom);
        td[105:94]  = 12'($urandom);
        td[137:106] = $urandom;
        return td;
    endfunction

    task automatic add_write(int side, int idx, logic [31:0] val);
        t_request q;
        q = '{default: '0};
        q.kind = ACT_WRITE;
        q.data[93:92] = 2'(side);
        q.data[105:94] = 12'(idx);
        q.data[137:106] = val;
        q.data[9:0] = 10'($urandom);
        q.data[42:19] = 24'($urandom);
        gen_written[side * AREA + idx] = 1'b1;
        n_items++;
        pending.push_back(q);
    endtask

    // A pixel whose texel is still unwritten gets a write of that texel first.
    task automatic add_pixel(logic [143:0] td);
        t_request q;
        int addr;
        addr = texel_addr(td);
        if (addr >= 0 && !gen_written[addr])
            add_write(addr / AREA, addr % AREA, $urandom);
        q = '{default: '0};
        q.kind = ACT_PIXEL;
        q.data = td;
        n_items++;
        pending.push_back(q);
    endtask

    task automatic add_cfg(logic idx, logic [23:0] val);
        t_request q;
        q = '{default: '0};
        q.is_drain = 1;
        pending.push_back(q);
        q.is_drain = 0;
        q.is_cfg = 1;
        q.cfg_idx = idx;
        q.cfg_val = val;
        pending.push_back(q);
    endtask

    // Fill the request queue: directed pixels, then a random mix.
    initial begin
        logic [143:0] td;
        bit mid_cfg_done;
        mid_cfg_done = 0;
        add_cfg(CFG_CEILING, 24'hFFFFFF);
        add_cfg(CFG_FLOOR, 24'h000000);
        add_write(2, 0, 32'hFFFFFFFF);
        add_write(1, 4095, 32'h0);
        // Directed pixels: zero length, far walls, row extremes, both axes.
        for (int k = 0; k < 20; k++) begin
            td = rand_fields();
            case (k)
                0: begin td[42:19] = 0; td[18:10] = 225; end
                1: begin td[42:19] = 24'hFFFFFF; td[18:10] = 225; end
                2: begin td[42:19] = 24'hFFFFFF; td[18:10] = 0; end
                3: begin td[42:19] = 0; td[18:10] = 0; end
                4: begin td[42:19] = 0; td[18:10] = 449; end
                5: begin td[18:10] = 511; end
                6: begin td[18:10] = 450; end
                7: begin td[42:19] = 1; td[66:43] = 24'hFFFFFF; td[91] = 0; end
                8: begin td[42:19] = 1; td[90:67] = 24'h00FFFF; td[91] = 1; end
                9: begin td[42:19] = 65536; td[18:10] = 226; td[58:43] = 0; end
                10: begin td[42:19] = 65536; td[18:10] = 224; td[9:0] = 1023; end
                11: begin td[42:19] = 90000; td[18:10] = 225; end
                12: begin td[42:19] = 95000; td[18:10] = 226; end
                default: ;
            endcase
            add_pixel(td);
        end
        add_cfg(CFG_CEILING, 24'h123456);
        add_cfg(CFG_FLOOR, 24'hFFFFFF);
        // Random part: mostly pixels, some texel rewrites, a mid-run setting.
        while (n_items < N_ITEMS) begin
            if (!mid_cfg_done && n_items >= N_ITEMS / 2) begin
                add_cfg(CFG_CEILING, 24'($urandom));
                add_cfg(CFG_FLOOR, 24'($urandom));
                mid_cfg_done = 1;
            end
            if ($urandom_range(0, 9) == 0)
                add_write(int'($urandom_range(0, 3)), int'($urandom_range(0, AREA - 1)),
                          $urandom);
            else add_pixel(rand_fields());
        end
        add_cfg(CFG_CEILING, 24'h000000);
        add_pixel(rand_fields());
    end

    // Reset sequence.
    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1;
    end

    // Idle patterns: a calm stretch and one long receiver hold-off.
    int cyc = 0;
    always @(posedge i_clk) begin
        cyc <= cyc + 1;
        quiet <= (cyc >= 150 && cyc < 450);
        if (!hold_done && pixels_seen == 40) begin
            hold_off  <= 200;
            hold_done <= 1;
        end else if (hold_off > 0) begin
            hold_off <= hold_off - 1;
        end
    end

    // Driver: requests, drains and register writes from the queue.
    int drain_wait = 0;
    always @(posedge i_clk) begin
        t_request q;
        t_pixel   want;
        bit       fire;
        bit       cfg_we;
        cfg_we = 1'b0;
        if (i_rst_n) begin
            fire = i_s_tvalid && o_s_tready;
            if (fire) begin
                if (i_s_tuser == ACT_WRITE) begin
                    tex_words[int'(i_s_tdata[93:92]) * AREA + int'(i_s_tdata[105:94])] <=
                        i_s_tdata[137:106];
                    writes_sent <= writes_sent + 1;
                end else begin
                    want.column = i_s_tdata[9:0];
                    want.row    = i_s_tdata[18:10];
                    want.colour = pixel_colour(i_s_tdata);
                    expected_pixels.push_back(want);
                end
            end
            if (i_s_tvalid && !fire) begin
                // Hold the current request until it is taken.
            end else if (pending.size() == 0) begin
                i_s_tvalid <= 0;
                stimulus_done <= 1;
            end else begin
                q = pending[0];
                if (q.is_drain) begin
                    i_s_tvalid <= 0;
                    if (expected_pixels.size() == 0 && !fire) begin
                        if (drain_wait >= LAT + 4) begin
                            void'(pending.pop_front());
                            drain_wait <= 0;
                        end else drain_wait <= drain_wait + 1;
                    end else drain_wait <= 0;
                end else if (q.is_cfg) begin
                    i_s_tvalid <= 0;
                    cfg_we = 1'b1;
                    i_cfg_addr <= q.cfg_idx;
                    i_cfg_wdata <= q.cfg_val;
                    if (q.cfg_idx == CFG_CEILING) ceil_rgb <= q.cfg_val;
                    else floor_rgb <= q.cfg_val;
                    void'(pending.pop_front());
                end else if (quiet || $urandom_range(0, 99) >= 36) begin
                    i_s_tvalid <= 1;
                    i_s_tuser <= q.kind;
                    i_s_tdata <= q.data;
                    void'(pending.pop_front());
                end else begin
                    i_s_tvalid <= 0;
                end
            end
        end
        i_cfg_we <= cfg_we;
    end

    // Monitor: compare each result with the oldest expected pixel.
    always @(posedge i_clk) begin
        t_pixel got, want;
        if (i_rst_n) begin
            i_m_tready <= (hold_off == 0) && (quiet || $urandom_range(0, 99) >= 36);
            if (o_m_tvalid && i_m_tready) begin
                got = t_pixel'(o_m_tdata[50:0]);
                pixels_seen <= pixels_seen + 1;
                if (expected_pixels.size() == 0) begin
                    mismatches <= mismatches + 1;
                    if (mismatches < 10)
                        $display("unexpected pixel col=%0d row=%0d colour=%h",
                                 got.column, got.row, got.colour);
                end else begin
                    want = expected_pixels.pop_front();
                    if (got !== want) begin
                        mismatches <= mismatches + 1;
                        if (mismatches < 10)
                            $display("pixel mismatch: expected %0d/%0d %h got %0d/%0d %h",
                                     want.column, want.row, want.colour,
                                     got.column, got.row, got.colour);
                    end
                end
            end
        end
    end

    // Watchdog and end of run.
    int stuck = 0;
    int tail = 0;
    always @(posedge i_clk) begin
        if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready) || i_cfg_we ||
            !i_rst_n)
            stuck <= 0;
        else stuck <= stuck + 1;
        if (stuck > WATCHDOG) begin
            $display("TB_ERROR");
            $finish;
        end else if (stimulus_done && expected_pixels.size() == 0) begin
            tail <= tail + 1;
            if (tail == 2 * LAT) begin
                $display("Wrote %0d texels and checked %0d pixels over ceiling, wall",
                         writes_sent, pixels_seen);
                $display("and floor rows, with stalls, a long hold-off and color changes.");
                if (mismatches == 0) $display("TB_OK");
                else $display("TB_ERROR");
                $finish;
            end
        end
    end

endmodule

`default_nettype wire
